// ----- rtl/core/sus_pkg.sv -----
// shared types, codes and defaults for the sorted unique set insert core
`default_nettype none

package sus_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int VALUE_W      = 32;
	localparam int FIELD_W      = 7;
	localparam int STATUS_W     = 2;

	localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_PRESENT  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

	typedef logic signed [VALUE_W-1:0] value_t;

	typedef struct packed {
		logic lt;
		logic eq;
	} cell_flags_t;

endpackage

`default_nettype wire

// ----- rtl/core/sus_cell.sv -----
// one storage cell of the sorted row: compare against the incoming word and shift
`default_nettype none

module sus_cell
	import sus_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        shift_en,
	input  wire logic        valid,
	input  wire value_t      insert_value,
	input  wire value_t      left_entry,
	input  wire logic        left_lt,
	output value_t           entry,
	output cell_flags_t      flags
);

	value_t entry_q;

	assign entry    = entry_q;
	assign flags.lt = valid && (entry_q < insert_value);
	assign flags.eq = valid && (entry_q == insert_value);

	always_ff @(posedge clk) begin
		if (shift_en && !flags.lt) begin
			entry_q <= left_lt ? insert_value : left_entry;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/sus_locate.sv -----
// reduces the cell flags to the duplicate flag and the insertion index
`default_nettype none

module sus_locate
	import sus_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
	input  wire cell_flags_t       flags [CAPACITY],
	output logic                   dup,
	output logic [CNT_W-1:0]       pos
);

	always_comb begin
		logic left_lt;
		logic here_lt;
		dup     = 1'b0;
		pos     = '0;
		left_lt = 1'b1;
		for (int i = 0; i < CAPACITY; i++) begin
			here_lt = flags[i].lt;
			if (left_lt && !here_lt) begin
				pos = pos | CNT_W'(i);
			end
			left_lt = here_lt;
		end
		// every stored word below the new one: index just past the row
		if (left_lt) begin
			pos = pos | CNT_W'(CAPACITY);
		end
		for (int i = 0; i < CAPACITY; i++) begin
			dup = dup | flags[i].eq;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/sorted_unique_set_insert_core.sv -----
// top level: sorted unique set held in a row of compare-and-shift cells
//
// s_tdata carries one signed 32-bit word per item. every accepted word is
// compared in all cells at once; the cells below it hold, the cell at the
// insertion index loads it and the cells above take their left neighbor,
// so an insert finishes in the cycle it is accepted.
// one result word per input on m_tdata: status, position and entry total.
// the result is registered and valid in the cycle after acceptance.
// throughput: one item per cycle while results are taken, set by the compare
// and reduce across the whole row of cells.
// the result sits in an output register; while m_tready is low a new item is
// still taken if that register is empty, otherwise s_tready drops.
// arst_n clears the entry count and the output valid; the cell contents are
// not cleared, entries at or above the count are never looked at.
// when the row is full a new value is dropped with status full.
`default_nettype none

module sorted_unique_set_insert_core
	import sus_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // insert_value[31:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata   // status[1:0], position[8:2], entry_total[15:9]
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	value_t             insert_value;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   pos;
	logic               dup;
	logic               full;
	logic               accept;
	logic               insert_en;
	logic               m_tvalid_q;
	logic [15:0]        m_tdata_q;
	logic [STATUS_W-1:0] status;
	logic [CNT_W-1:0]   res_pos;
	logic [CNT_W-1:0]   res_total;
	logic [CNT_W+FIELD_W-1:0] pos_ext;
	logic [CNT_W+FIELD_W-1:0] total_ext;
	logic [CAPACITY-1:0] eq_vec;

	value_t      entries [CAPACITY];
	cell_flags_t flags   [CAPACITY];

	assign insert_value = value_t'(s_tdata);
	assign accept       = s_tvalid && s_tready;
	assign s_tready     = !m_tvalid_q || m_tready;
	assign full         = (count_q == CNT_W'(CAPACITY));
	assign insert_en    = accept && !dup && !full;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_first
			sus_cell u_cell (
				.clk          (clk),
				.shift_en     (insert_en),
				.valid        (count_q > CNT_W'(i)),
				.insert_value (insert_value),
				.left_entry   (insert_value),
				.left_lt      (1'b1),
				.entry        (entries[i]),
				.flags        (flags[i])
			);
		end else begin : g_rest
			sus_cell u_cell (
				.clk          (clk),
				.shift_en     (insert_en),
				.valid        (count_q > CNT_W'(i)),
				.insert_value (insert_value),
				.left_entry   (entries[i-1]),
				.left_lt      (flags[i-1].lt),
				.entry        (entries[i]),
				.flags        (flags[i])
			);
		end
		assign eq_vec[i] = flags[i].eq;
	end

	sus_locate #(
		.CAPACITY (CAPACITY),
		.CNT_W    (CNT_W)
	) u_locate (
		.flags (flags),
		.dup   (dup),
		.pos   (pos)
	);

	always_comb begin
		if (dup) begin
			status    = ST_PRESENT;
			res_pos   = pos;
			res_total = count_q;
		end else if (full) begin
			status    = ST_FULL;
			res_pos   = '0;
			res_total = count_q;
		end else begin
			status    = ST_INSERTED;
			res_pos   = pos;
			res_total = count_q + CNT_W'(1);
		end
		pos_ext   = {{FIELD_W{1'b0}}, res_pos};
		total_ext = {{FIELD_W{1'b0}}, res_total};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (insert_en) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (accept) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= {total_ext[FIELD_W-1:0], pos_ext[FIELD_W-1:0], status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(eq_vec))
		else $error("stored word matches in more than one cell");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		insert_en |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not advance the count");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted word produced no result");

endmodule

`default_nettype wire
